FILE: hw/rtl/png_unf_pkg.sv
// Shared types and constants for the PNG scanline unfilter (8-bit RGBA).
// Holds the channel payload structs, the filter codes and the job record
// passed from the front end to the back end. No dependencies.
package png_unf_pkg;

    // Geometry of the image rows.
    localparam int MAX_ROW_PIXELS  = 4096;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int ROW_BYTES_MAX   = MAX_ROW_PIXELS * BYTES_PER_PIXEL;

    // Field widths.
    localparam int PX_W   = 13;                          // row_pixels register
    localparam int COL_W  = $clog2(ROW_BYTES_MAX);       // byte column in a row
    localparam int RB_W   = $clog2(ROW_BYTES_MAX + 1);   // row length in bytes
    localparam int SLOT_W = $clog2(BYTES_PER_PIXEL);     // byte lane in a pixel

    // Depth of the queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Filter type codes of a row.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       bad_filter;
    } t_out_item;

    // One pixel byte, classified by the front end.
    typedef struct packed {
        logic [7:0]       data;
        logic [COL_W-1:0] col;
        t_filter          filter;
        logic             first_row;
        logic             bad;
        logic             last;
    } t_job;

endpackage

FILE: hw/rtl/png_scanline_unfilter_rgba8.sv
// Top level of the PNG scanline unfilter for 8-bit RGBA pixels.
// Depends on png_unf_pkg, png_unf_front, png_unf_fifo and png_unf_back.
//
// The block takes the inflated image stream one byte per transaction and
// returns one reconstructed byte for every pixel byte; the filter-type byte
// that opens each row is consumed without a result. It sustains one byte per
// clock cycle in both directions while the output is not held off. An accepted
// pixel byte is written into the queue, moves from the queue into the read
// stage while its prior-row byte is read from the line buffer, and is then
// reconstructed and loaded into the output register. The line buffer holds
// 16384 bytes and needs no clearing after reset, as the first row of each
// image takes its prior row as zero. Set row_pixels only while the block is
// idle.
module png_scanline_unfilter_rgba8
    import png_unf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [PX_W-1:0] i_cfg_data
);

    logic job_push_valid;
    logic job_push_ready;
    t_job job_push;
    logic job_pop_valid;
    logic job_pop_ready;
    t_job job_pop;

    // Classifies bytes and tracks rows.
    png_unf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (job_push_valid),
        .i_job_ready (job_push_ready),
        .o_job       (job_push)
    );

    // Decouples the two halves.
    png_unf_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_push_valid),
        .o_push_ready (job_push_ready),
        .i_push_data  (job_push),
        .o_pop_valid  (job_pop_valid),
        .i_pop_ready  (job_pop_ready),
        .o_pop_data   (job_pop)
    );

    // Reconstructs the pixel bytes.
    png_unf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_pop_valid),
        .o_job_ready (job_pop_ready),
        .i_job       (job_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hw/rtl/png_unf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module png_unf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/png_unf_fifo.sv
// Short job queue between the front end and the back end.
// Depends on png_unf_pkg for the job record and the queue depth.
module png_unf_fifo
    import png_unf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    // Entry storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/png_unf_front.sv
// Front end: holds the row length register, takes input transactions,
// consumes filter-type bytes and turns pixel bytes into jobs for the queue.
// Depends on png_unf_pkg.
module png_unf_front
    import png_unf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [PX_W-1:0] i_cfg_data,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output t_job            o_job
);

    logic [RB_W-1:0]  r_row_bytes;
    logic [RB_W-1:0]  n_row_bytes;
    logic [PX_W-1:0]  cfg_px;
    logic             r_awaiting;
    logic             n_awaiting;
    logic             r_first_row;
    logic             n_first_row;
    logic             r_row_bad;
    logic             n_row_bad;
    t_filter          r_filter;
    t_filter          n_filter;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             accept;
    logic             is_filter;
    logic             first_eff;
    logic             last;

    // Configuration is always taken; the row length in bytes is kept ready.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg_px = i_cfg_data;
        if (cfg_px == '0) begin
            cfg_px = PX_W'(1);
        end else if (cfg_px > PX_W'(MAX_ROW_PIXELS)) begin
            cfg_px = PX_W'(MAX_ROW_PIXELS);
        end
        n_row_bytes = r_row_bytes;
        if (i_cfg_valid) begin
            n_row_bytes = RB_W'(RB_W'(cfg_px) * RB_W'(BYTES_PER_PIXEL));
        end
    end

    // Input is held off only when the queue is full.
    assign o_in_ready = i_job_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_filter  = r_awaiting || i_in_data.frame_start;
    assign first_eff  = r_first_row || i_in_data.frame_start;
    assign last       = ((RB_W'(r_col) + 1'b1) >= r_row_bytes);

    // Job record for a pixel byte.
    assign o_job_valid     = accept && !is_filter;
    assign o_job.data      = i_in_data.data_byte;
    assign o_job.col       = r_col;
    assign o_job.filter    = r_filter;
    assign o_job.first_row = r_first_row;
    assign o_job.bad       = r_row_bad;
    assign o_job.last      = last;

    // Row tracking: filter byte, byte column and first-row flag.
    always_comb begin
        n_awaiting  = r_awaiting;
        n_first_row = r_first_row;
        n_row_bad   = r_row_bad;
        n_filter    = r_filter;
        n_col       = r_col;
        if (accept) begin
            if (is_filter) begin
                if (i_in_data.data_byte > 8'(FILT_PAETH)) begin
                    n_row_bad = 1'b1;
                    n_filter  = FILT_NONE;
                end else begin
                    n_row_bad = 1'b0;
                    n_filter  = t_filter'(i_in_data.data_byte[2:0]);
                end
                n_col       = '0;
                n_awaiting  = 1'b0;
                n_first_row = first_eff;
            end else if (last) begin
                n_col       = '0;
                n_awaiting  = 1'b1;
                n_first_row = 1'b0;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= RB_W'(BYTES_PER_PIXEL);
            r_awaiting  <= 1'b1;
            r_first_row <= 1'b1;
            r_row_bad   <= 1'b0;
            r_filter    <= FILT_NONE;
            r_col       <= '0;
        end else begin
            r_row_bytes <= n_row_bytes;
            r_awaiting  <= n_awaiting;
            r_first_row <= n_first_row;
            r_row_bad   <= n_row_bad;
            r_filter    <= n_filter;
            r_col       <= n_col;
        end
    end

endmodule

FILE: hw/rtl/png_unf_back.sv
// Back end: reads the prior-row byte, reconstructs the pixel byte with the
// row's filter, writes it back to the line buffer and drives the output register.
// Depends on png_unf_pkg and png_unf_ram.
module png_unf_back
    import png_unf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic              issue;
    logic              r_b_vld;
    t_job              r_b_job;
    logic              b_adv;
    logic [7:0]        rd_data;
    logic [7:0]        r_left  [BYTES_PER_PIXEL];
    logic [7:0]        r_upl   [BYTES_PER_PIXEL];
    logic [SLOT_W-1:0] slot;
    logic              at_edge;
    logic [7:0]        op_a;
    logic [7:0]        op_b;
    logic [7:0]        op_c;
    logic [8:0]        avg_sum;
    logic [7:0]        pred;
    logic [7:0]        value;
    logic              r_out_vld;
    t_out_item         r_out;

    // Paeth predictor: the neighbour closest to a + b - c, ties to a then b.
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        logic [9:0]        abs_a;
        logic [9:0]        abs_b;
        logic [9:0]        abs_c;
        pa    = $signed({2'b00, b}) - $signed({2'b00, c});
        pb    = $signed({2'b00, a}) - $signed({2'b00, c});
        pc    = pa + pb;
        abs_a = (pa < 0) ? 10'(-pa) : 10'(pa);
        abs_b = (pb < 0) ? 10'(-pb) : 10'(pb);
        abs_c = (pc < 0) ? 10'(-pc) : 10'(pc);
        if (abs_a <= abs_b && abs_a <= abs_c) begin
            return a;
        end else if (abs_b <= abs_c) begin
            return b;
        end
        return c;
    endfunction

    // Pipeline handshakes: the read stage advances when the compute stage frees up.
    assign b_adv       = r_b_vld && (!r_out_vld || i_out_ready);
    assign o_job_ready = !r_b_vld || b_adv;
    assign issue       = i_job_valid && o_job_ready;

    // Line buffer holding the prior row.
    png_unf_ram #(
        .WIDTH (8),
        .DEPTH (ROW_BYTES_MAX)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (b_adv),
        .i_wr_addr (r_b_job.col),
        .i_wr_data (value),
        .i_rd_en   (issue),
        .i_rd_addr (i_job.col),
        .o_rd_data (rd_data)
    );

    // Operands: left and upper-left are zero in the first pixel of a row.
    assign slot    = r_b_job.col[SLOT_W-1:0];
    assign at_edge = (r_b_job.col < COL_W'(BYTES_PER_PIXEL));
    assign op_a    = at_edge ? 8'd0 : r_left[slot];
    assign op_c    = at_edge ? 8'd0 : r_upl[slot];
    assign op_b    = r_b_job.first_row ? 8'd0 : rd_data;
    assign avg_sum = {1'b0, op_a} + {1'b0, op_b};

    // Filter decoder.
    always_comb begin
        unique case (r_b_job.filter)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = op_a;
            FILT_UP:    pred = op_b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(op_a, op_b, op_c);
            default:    pred = 8'd0;
        endcase
    end

    assign value = r_b_job.data + pred;

    // Left and upper-left neighbour bytes, the read-stage job and the output payload; payload only.
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_left[slot] <= value;
            r_upl[slot]  <= op_b;
        end
        if (issue) begin
            r_b_job <= i_job;
        end
        if (b_adv) begin
            r_out.pixel_byte <= value;
            r_out.row_end    <= r_b_job.last;
            r_out.bad_filter <= r_b_job.bad;
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (issue) begin
                r_b_vld <= 1'b1;
            end else if (b_adv) begin
                r_b_vld <= 1'b0;
            end
            if (b_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
